// ----- hw/rtl/rshf_pkg.sv -----
// Shared types and constants for the ray against wall segment hit test.
package rshf_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int CSR_ADDR_BITS  = 1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SNAP_THRESHOLD = 1'b0;
   localparam logic [FRAC_BITS_DEF:0] SNAP_RESET = 17'd1;

   typedef struct packed {
      logic signed [COORD_BITS_DEF-1:0] origin_x;
      logic signed [COORD_BITS_DEF-1:0] origin_y;
      logic signed [COORD_BITS_DEF-1:0] motion_x;
      logic signed [COORD_BITS_DEF-1:0] motion_y;
      logic signed [COORD_BITS_DEF-1:0] wall_start_x;
      logic signed [COORD_BITS_DEF-1:0] wall_start_y;
      logic signed [COORD_BITS_DEF-1:0] wall_end_x;
      logic signed [COORD_BITS_DEF-1:0] wall_end_y;
   } req_type;

   typedef struct packed {
      logic                   hit;
      logic [FRAC_BITS_DEF:0] hit_fraction;
   } rsp_type;

endpackage

// ----- hw/rtl/rshf_front.sv -----
// Front stages: differences, cross products, sign fix and the range tests.
module rshf_front import rshf_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int PROD_BITS  = 2 * COORD_BITS + 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  req_type                     in_req,
   output logic                        out_valid,
   output logic                        out_ok,
   output logic [PROD_BITS-2:0]        out_den,
   output logic [PROD_BITS-2:0]        out_tnum
);
   localparam int DB = COORD_BITS + 1;

   // Stage 1: coordinate differences.
   logic                 v1_ff;
   logic signed [DB-1:0] dx_ff, dy_ff, ex_ff, ey_ff, vx_ff, vy_ff;
   // Stage 2: cross products.
   logic                        v2_ff;
   logic signed [PROD_BITS-1:0] den_ff, tnum_ff, unum_ff;
   logic signed [PROD_BITS-1:0] den_in, tnum_in, unum_in;
   logic signed [PROD_BITS-1:0] aden, atnum, aunum;

   assign den_in  = PROD_BITS'(dx_ff * vy_ff) - PROD_BITS'(dy_ff * vx_ff);
   // ex, ey hold wall_start - origin, so unum = -(e x motion).
   assign tnum_in = PROD_BITS'(dx_ff * ey_ff) - PROD_BITS'(dy_ff * ex_ff);
   assign unum_in = PROD_BITS'(ey_ff * vx_ff) - PROD_BITS'(ex_ff * vy_ff);

   always_comb begin
      if (den_ff < 0) begin
         aden  = -den_ff;
         atnum = -tnum_ff;
         aunum = -unum_ff;
      end else begin
         aden  = den_ff;
         atnum = tnum_ff;
         aunum = unum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         out_valid <= 1'b0;
      end else begin
         v1_ff     <= in_valid;
         v2_ff     <= v1_ff;
         out_valid <= v2_ff;
      end
      dx_ff   <= DB'(in_req.wall_end_x) - DB'(in_req.wall_start_x);
      dy_ff   <= DB'(in_req.wall_end_y) - DB'(in_req.wall_start_y);
      ex_ff   <= DB'(in_req.wall_start_x) - DB'(in_req.origin_x);
      ey_ff   <= DB'(in_req.wall_start_y) - DB'(in_req.origin_y);
      vx_ff   <= DB'(in_req.motion_x);
      vy_ff   <= DB'(in_req.motion_y);
      den_ff  <= den_in;
      tnum_ff <= tnum_in;
      unum_ff <= unum_in;
      out_ok  <= (den_ff != 0) && (atnum >= 0) && (atnum <= aden)
                 && (aunum >= 0) && (aunum <= aden);
      out_den  <= aden[PROD_BITS-2:0];
      out_tnum <= atnum[PROD_BITS-2:0];
   end
endmodule

// ----- hw/rtl/rshf_div_cell.sv -----
// One restoring division cell: produces one quotient bit and passes on.
module rshf_div_cell import rshf_pkg::*; #(
   parameter int VAL_BITS  = 2 * COORD_BITS_DEF + 2,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter bit FIRST     = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 in_ok,
   input  logic [VAL_BITS-1:0]  in_den,
   input  logic [VAL_BITS-1:0]  in_rem,
   input  logic [FRAC_BITS:0]   in_quo,
   output logic                 out_valid,
   output logic                 out_ok,
   output logic [VAL_BITS-1:0]  out_den,
   output logic [VAL_BITS-1:0]  out_rem,
   output logic [FRAC_BITS:0]   out_quo
);
   // Remainder stays below den, so one extra bit covers the doubling.
   logic [VAL_BITS:0] trial;
   logic              ge;

   assign trial = FIRST ? {1'b0, in_rem} : {in_rem, 1'b0};
   assign ge    = trial >= {1'b0, in_den};

   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else       out_valid <= in_valid;
      out_ok  <= in_ok;
      out_den <= in_den;
      out_rem <= ge ? VAL_BITS'(trial - {1'b0, in_den}) : trial[VAL_BITS-1:0];
      out_quo <= FIRST ? (FRAC_BITS+1)'(ge) : {in_quo[FRAC_BITS-1:0], ge};
   end
endmodule

// ----- hw/rtl/ray_segment_hit_fraction.sv -----
// Top level of the pipelined ray against wall segment hit test.
// Usage: pulse start with a request on req_data while busy is low; busy is
// never raised, so a request may enter every cycle. Each request yields
// exactly one result on rsp_data, marked by rsp_valid for one cycle, in
// request order. Three front stages form the cross products and range tests,
// then a chain of FRAC_BITS + 1 division cells produces one quotient bit per
// cell, and a final register applies the snap threshold and the miss case.
// Throughput is one request per cycle.
// The receiver cannot stall; results are shown once and must be taken.
// The snap threshold register sits at APB address 0 and resets to 1; write
// it only while no request is in flight. Reset clears all valid flags.
module ray_segment_hit_fraction import rshf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   // The request and result types fix these widths.
   localparam int COORD_BITS = COORD_BITS_DEF;
   localparam int FRAC_BITS  = FRAC_BITS_DEF;
   localparam int PROD_BITS = 2 * COORD_BITS + 3;
   localparam int VB        = PROD_BITS - 1;
   localparam int NCELL     = FRAC_BITS + 1;

   logic [FRAC_BITS:0] snap_ff;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign prdata = 32'(snap_ff);

   always_ff @(posedge clock) begin
      if (reset) snap_ff <= (FRAC_BITS+1)'(SNAP_RESET);
      else if (psel && penable && pwrite && paddr == CSR_SNAP_THRESHOLD)
         snap_ff <= pwdata[FRAC_BITS:0];
   end

   logic                v_c [NCELL+1];
   logic                ok_c[NCELL+1];
   logic [VB-1:0]       den_c[NCELL+1];
   logic [VB-1:0]       rem_c[NCELL+1];
   logic [FRAC_BITS:0]  quo_c[NCELL+1];

   rshf_front #(.COORD_BITS(COORD_BITS), .PROD_BITS(PROD_BITS)) u_front (
      .clock, .reset,
      .in_valid (start),
      .in_req   (req_data),
      .out_valid(v_c[0]),
      .out_ok   (ok_c[0]),
      .out_den  (den_c[0]),
      .out_tnum (rem_c[0])
   );
   assign quo_c[0] = '0;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      rshf_div_cell #(.VAL_BITS(VB), .FRAC_BITS(FRAC_BITS), .FIRST(i == 0)) u_cell (
         .clock, .reset,
         .in_valid (v_c[i]),   .in_ok (ok_c[i]),   .in_den (den_c[i]),
         .in_rem   (rem_c[i]), .in_quo(quo_c[i]),
         .out_valid(v_c[i+1]), .out_ok(ok_c[i+1]), .out_den(den_c[i+1]),
         .out_rem  (rem_c[i+1]), .out_quo(quo_c[i+1])
      );
   end

   logic               q_small;
   assign q_small = quo_c[NCELL] < snap_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= v_c[NCELL];
      rsp_data.hit          <= ok_c[NCELL];
      rsp_data.hit_fraction <= (ok_c[NCELL] && !q_small) ? quo_c[NCELL] : '0;
   end
endmodule
